/* src/iba_pkg.sv */
// Shared types and constants for the inode bitmap allocator.
// Used by the channel interfaces and by the top level; no dependencies.
`default_nettype none

package iba_pkg;

  localparam int unsigned BITMAP_BYTES_DEF = 512;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned INO_W     = 12;
  localparam int unsigned BIDX_W    = 9;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] FULL_BYTE     = 8'hff;
  localparam int unsigned       BITS_PER_BYTE = 8;

  localparam logic [INO_W-1:0] FIRST_USER_RST = 12'd1;
  localparam logic [CNT_W-1:0] LIMIT_RST      = 13'd4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC      = 2'd0,
    CMD_FREE       = 2'd1,
    CMD_LOAD_BYTE  = 2'd2,
    CMD_LOAD_COUNT = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_INVALID      = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_NO_FREE      = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_USER = 1'b0,
    CFG_LIMIT      = 1'b1
  } cfg_idx_e;

endpackage

`default_nettype wire

/* src/iba_if.sv */
// Valid/ready channel interfaces of the inode bitmap allocator:
// command beats in, result beats out, and the configuration write channel.
// Depends on iba_pkg for the field widths.
`default_nettype none

interface iba_req_if;
  import iba_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [INO_W-1:0]  inode_number;
  logic [BIDX_W-1:0] byte_index;
  logic [BYTE_W-1:0] byte_value;
  logic [CNT_W-1:0]  count_value;

  modport source (output valid, command, inode_number, byte_index, byte_value, count_value,
                  input ready);
  modport sink (input valid, command, inode_number, byte_index, byte_value, count_value,
                output ready);
endinterface

interface iba_rsp_if;
  import iba_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INO_W-1:0]    allocated_inode;
  logic [CNT_W-1:0]    free_inodes;

  modport source (output valid, status, allocated_inode, free_inodes, input ready);
  modport sink (input valid, status, allocated_inode, free_inodes, output ready);
endinterface

interface iba_cfg_if;
  import iba_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/iba_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module iba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/inode_bitmap_allocator.sv */
// Inode bitmap allocator: first-fit allocate and free over a bitmap in RAM.
// Depends on iba_pkg, the interfaces in iba_if.sv and the RAM in iba_ram.sv.
//
// Usage. Command beats arrive on req_i (allocate, free, load bitmap byte,
// load free count); every command yields exactly one result beat on rsp_o
// carrying a status, the allocated inode and the free counter after it.
// cfg_i writes first_user_inode (index 0) and inode_limit (index 1); it is
// always ready and must only be used while no command is in flight.
// Steps from accept to result valid: a load goes straight to completion; a
// free reads the bitmap byte and clears the bit if it is set; an allocate
// reads bitmap bytes from the byte holding first_user_inode up to the first
// byte with a clear bit (at most BITMAP_BYTES). The bitmap RAM read port, one
// byte per cycle, sets the scan rate. One command is worked on at a time; the
// next beat is taken as soon as the sequencer is back in idle, even when the
// previous result still sits unclaimed in the output register.
// Reset initialises the control registers and then runs a clearing pass that
// writes zero to every bitmap byte, during which req_i is not ready.
// If the receiver stalls, the finished result waits in the output register;
// a following command runs to completion and then holds its result until the
// output register drains.
`default_nettype none

module inode_bitmap_allocator #(
  parameter int unsigned BITMAP_BYTES = iba_pkg::BITMAP_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iba_req_if.sink    req_i,
  iba_rsp_if.source  rsp_o,
  iba_cfg_if.sink    cfg_i
);
  import iba_pkg::*;

  localparam int unsigned AW    = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned SHIFT = $clog2(BITS_PER_BYTE);
  localparam int unsigned FW    = AW + SHIFT;
  // Compare width wide enough for both the bitmap depth and a byte index.
  localparam int unsigned XW    = (CW > BIDX_W + 1) ? CW : BIDX_W + 1;

  localparam logic [XW-1:0] DEPTH_X = XW'(BITMAP_BYTES);
  localparam logic [CW-1:0] DEPTH_C = CW'(BITMAP_BYTES);

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_SCAN     = 6'b000100,
    S_FREE_RD  = 6'b001000,
    S_FREE_CHK = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  // Position of the lowest clear bit of a byte.
  function automatic logic [SHIFT-1:0] lowest_zero(input logic [BYTE_W-1:0] v);
    logic [SHIFT-1:0] idx;
    idx = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (!v[i]) begin
        idx = SHIFT'(i);
      end
    end
    return idx;
  endfunction

  state_e              state_q, state_d;
  logic [INO_W-1:0]    fui_q, fui_d;
  logic [CNT_W-1:0]    limit_q, limit_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]       clr_q, clr_d;
  logic [CW-1:0]       addr_q, addr_d;
  logic                vld_q, vld_d;
  logic                out_vld_q, out_vld_d;

  logic [AW-1:0]       prev_q, prev_d;
  logic [AW-1:0]       op_addr_q, op_addr_d;
  logic [SHIFT-1:0]    op_bit_q, op_bit_d;
  status_e             status_q, status_d;
  logic [INO_W-1:0]    alloc_q, alloc_d;
  status_e             out_status_q, out_status_d;
  logic [INO_W-1:0]    out_alloc_q, out_alloc_d;
  logic [CNT_W-1:0]    out_free_q, out_free_d;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  logic                req_accept;
  cmd_e                cmd;
  logic [BIDX_W-1:0]   start_byte;
  logic [BIDX_W-1:0]   ino_byte;
  logic                free_bad;
  logic [SHIFT-1:0]    zero_idx;
  logic [FW-1:0]       found;
  logic                hit;
  logic [CNT_W:0]      cnt_inc;
  logic [CNT_W-1:0]    cnt_sat;
  logic [BYTE_W-1:0]   op_mask;

  iba_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BITMAP_BYTES)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign req_accept  = req_i.valid && req_i.ready;
  assign cmd         = cmd_e'(req_i.command);
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.allocated_inode = out_alloc_q;
  assign rsp_o.free_inodes     = out_free_q;

  // The scan starts at the byte holding first_user_inode.
  assign start_byte = fui_q[INO_W-1:SHIFT];
  assign ino_byte   = req_i.inode_number[INO_W-1:SHIFT];

  // A free is invalid at or below the reserved range, at or above the limit,
  // or outside the bitmap.
  assign free_bad = (req_i.inode_number <= fui_q)
                 || ({1'b0, req_i.inode_number} >= limit_q)
                 || (XW'(ino_byte) >= DEPTH_X);

  // Scan check: the read data belongs to the byte issued in the cycle before.
  assign zero_idx = lowest_zero(ram_rdata);
  assign found    = {prev_q, zero_idx};
  assign hit      = vld_q && (ram_rdata != FULL_BYTE);

  // Free raises the counter, saturating at the inode limit.
  assign cnt_inc = {1'b0, cnt_q} + (CNT_W + 1)'(1);
  assign cnt_sat = (cnt_inc > {1'b0, limit_q}) ? limit_q : cnt_inc[CNT_W-1:0];
  assign op_mask = BYTE_W'(1) << op_bit_q;

  always_comb begin
    state_d      = state_q;
    fui_d        = fui_q;
    limit_d      = limit_q;
    cnt_d        = cnt_q;
    clr_d        = clr_q;
    addr_d       = addr_q;
    vld_d        = vld_q;
    out_vld_d    = out_vld_q;
    prev_d       = prev_q;
    op_addr_d    = op_addr_q;
    op_bit_d     = op_bit_q;
    status_d     = status_q;
    alloc_d      = alloc_q;
    out_status_d = out_status_q;
    out_alloc_d  = out_alloc_q;
    out_free_d   = out_free_q;
    ram_we       = 1'b0;
    ram_waddr    = op_addr_q;
    ram_wdata    = '0;
    ram_raddr    = op_addr_q;

    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_FIRST_USER: fui_d   = cfg_i.data[INO_W-1:0];
        CFG_LIMIT:      limit_d = cfg_i.data;
        default:        ;
      endcase
    end

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q[AW-1:0];
        ram_wdata = '0;
        clr_d     = clr_q + CW'(1);
        if (clr_q == DEPTH_C - CW'(1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_accept) begin
          status_d = ST_OK;
          alloc_d  = '0;
          unique case (cmd)
            CMD_ALLOC: begin
              if (XW'(start_byte) >= DEPTH_X) begin
                status_d = ST_NO_FREE;
                state_d  = S_DONE;
              end else begin
                addr_d  = CW'(start_byte);
                vld_d   = 1'b0;
                state_d = S_SCAN;
              end
            end
            CMD_FREE: begin
              if (free_bad) begin
                status_d = ST_INVALID;
                state_d  = S_DONE;
              end else begin
                op_addr_d = AW'(ino_byte);
                op_bit_d  = req_i.inode_number[SHIFT-1:0];
                state_d   = S_FREE_RD;
              end
            end
            CMD_LOAD_BYTE: begin
              // Loads outside the bitmap are dropped but still answered.
              if (XW'(req_i.byte_index) < DEPTH_X) begin
                ram_we    = 1'b1;
                ram_waddr = AW'(req_i.byte_index);
                ram_wdata = req_i.byte_value;
              end
              state_d = S_DONE;
            end
            CMD_LOAD_COUNT: begin
              cnt_d   = req_i.count_value;
              state_d = S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next byte while checking the one issued last cycle.
        ram_raddr = addr_q[AW-1:0];
        prev_d    = addr_q[AW-1:0];
        vld_d     = (addr_q != DEPTH_C);
        if (addr_q != DEPTH_C) begin
          addr_d = addr_q + CW'(1);
        end
        if (hit) begin
          // A clear bit for inode zero means nothing can be handed out.
          if (found == '0) begin
            status_d = ST_NO_FREE;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = prev_q;
            ram_wdata = ram_rdata | (BYTE_W'(1) << zero_idx);
            alloc_d   = INO_W'(found);
            if (cnt_q != '0) begin
              cnt_d = cnt_q - CNT_W'(1);
            end
          end
          state_d = S_DONE;
        end else if (addr_q == DEPTH_C) begin
          status_d = ST_NO_FREE;
          state_d  = S_DONE;
        end
      end

      S_FREE_RD: begin
        state_d = S_FREE_CHK;
      end

      S_FREE_CHK: begin
        if ((ram_rdata & op_mask) == '0) begin
          status_d = ST_ALREADY_FREE;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = op_addr_q;
          ram_wdata = ram_rdata & ~op_mask;
          cnt_d     = cnt_sat;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d    = 1'b1;
          out_status_d = status_q;
          out_alloc_d  = alloc_q;
          out_free_d   = cnt_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      fui_q     <= FIRST_USER_RST;
      limit_q   <= LIMIT_RST;
      cnt_q     <= '0;
      clr_q     <= '0;
      addr_q    <= '0;
      vld_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fui_q     <= fui_d;
      limit_q   <= limit_d;
      cnt_q     <= cnt_d;
      clr_q     <= clr_d;
      addr_q    <= addr_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q       <= prev_d;
    op_addr_q    <= op_addr_d;
    op_bit_q     <= op_bit_d;
    status_q     <= status_d;
    alloc_q      <= alloc_d;
    out_status_q <= out_status_d;
    out_alloc_q  <= out_alloc_d;
    out_free_q   <= out_free_d;
  end

  // A new result only ever comes out of the completion state.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_DONE))
    else $error("result appeared without a completed command");

  // The scan only writes back a byte that had a clear bit, never inode zero.
  a_scan_write_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && ram_we) |-> (vld_q && ram_rdata != FULL_BYTE && found != '0))
    else $error("scan wrote back a byte without a usable clear bit");

  // The scan pointer never runs past the end of the bitmap.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (addr_q <= DEPTH_C))
    else $error("scan address beyond the bitmap");

  // A free that writes back always changes the byte it read.
  a_free_changes_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FREE_CHK && ram_we) |-> (ram_wdata != ram_rdata))
    else $error("free wrote back an unchanged byte");

endmodule

`default_nettype wire
